/* src/weighted_pixel_accumulator_top_assert.svh */
// ----------------------------------------------------------------------------
// weighted_pixel_accumulator_top_assert.svh
// Assertion macros for the weighted pixel accumulator checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_PIXEL_ACCUMULATOR_TOP_ASSERT_SVH
`define WEIGHTED_PIXEL_ACCUMULATOR_TOP_ASSERT_SVH

// prop holds at every clock edge outside reset
`define WPA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expr never holds outside reset
`define WPA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* src/wpa_pkg.sv */
// ----------------------------------------------------------------------------
// wpa_pkg
// Shared constants, codes and types of the weighted pixel accumulator.
// ----------------------------------------------------------------------------
package wpa_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int SUM_BITS   = 40;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int IDX_W      = 16;
  localparam int COLOR_W    = 16;
  localparam int WEIGHT_W   = 16;
  localparam int WMAG_W     = WEIGHT_W - 1;
  localparam int FRAC_SHIFT = 14;
  localparam int MULT_W     = COLOR_W + WMAG_W;
  localparam int PROD_W     = MULT_W - FRAC_SHIFT;
  localparam int OUT_W      = 40;
  localparam int CNT_W      = 17;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [CNT_W-1:0]   PIXEL_COUNT_RST = CNT_W'(65536);
  localparam logic [PADDR_W-1:0] REG_PIXEL_COUNT = PADDR_W'(0);

  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DEPOSIT,
    KIND_READ,
    KIND_CLEAR
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEP_FETCH,
    ST_DEP_UPDATE,
    ST_RD_FETCH,
    ST_RD_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_step;
    logic update;
    logic respond;
  } ctrl_t;

  typedef struct packed {
    kind_t kind;
    logic  clr_last;
  } stat_t;

endpackage

/* src/wpa_ram.sv */
// ----------------------------------------------------------------------------
// wpa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module wpa_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

/* src/wpa_regs.sv */
// ----------------------------------------------------------------------------
// wpa_regs
// APB-style configuration register holding the valid pixel count.
// ----------------------------------------------------------------------------
module wpa_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wpa_pkg::PADDR_W-1:0]      paddr,
  input  logic [wpa_pkg::PDATA_W-1:0]      pwdata,
  output logic [wpa_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready,
  output logic [wpa_pkg::CNT_W-1:0]        pixel_count
);

  logic [wpa_pkg::CNT_W-1:0] pixel_count_r;
  logic [wpa_pkg::CNT_W-1:0] pixel_count_nxt;
  logic                      sel_count;

  assign sel_count = (paddr[wpa_pkg::PADDR_W-1:2] ==
                      wpa_pkg::REG_PIXEL_COUNT[wpa_pkg::PADDR_W-1:2]);

  always_comb begin
    pixel_count_nxt = pixel_count_r;
    if (psel && penable && pwrite && sel_count) begin
      pixel_count_nxt = pwdata[wpa_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= wpa_pkg::PIXEL_COUNT_RST;
    end else begin
      pixel_count_r <= pixel_count_nxt;
    end
  end

  assign pready      = 1'b1;
  assign prdata      = sel_count ? wpa_pkg::PDATA_W'(pixel_count_r) : '0;
  assign pixel_count = pixel_count_r;

endmodule

/* src/wpa_ctrl.sv */
// ----------------------------------------------------------------------------
// wpa_ctrl
// Sequencer for deposit, read and clear items.
// ----------------------------------------------------------------------------
module wpa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  wpa_pkg::stat_t  stat,
  output wpa_pkg::ctrl_t  ctrl,
  output logic            busy
);

  wpa_pkg::state_t state_r;
  wpa_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wpa_pkg::ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = wpa_pkg::ST_IDLE;
        end
      end
      wpa_pkg::ST_IDLE: begin
        if (start) begin
          case (stat.kind)
            wpa_pkg::KIND_DEPOSIT: state_nxt = wpa_pkg::ST_DEP_FETCH;
            wpa_pkg::KIND_READ:    state_nxt = wpa_pkg::ST_RD_FETCH;
            wpa_pkg::KIND_CLEAR:   state_nxt = wpa_pkg::ST_CLEAR;
            default:               state_nxt = wpa_pkg::ST_IDLE;
          endcase
        end
      end
      wpa_pkg::ST_DEP_FETCH:  state_nxt = wpa_pkg::ST_DEP_UPDATE;
      wpa_pkg::ST_DEP_UPDATE: state_nxt = wpa_pkg::ST_IDLE;
      wpa_pkg::ST_RD_FETCH:   state_nxt = wpa_pkg::ST_RD_RESP;
      wpa_pkg::ST_RD_RESP:    state_nxt = wpa_pkg::ST_IDLE;
      default:                state_nxt = wpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl            = '0;
    busy            = 1'b1;
    case (state_r)
      wpa_pkg::ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      wpa_pkg::ST_CLEAR:      ctrl.clear_step = 1'b1;
      wpa_pkg::ST_DEP_UPDATE: ctrl.update     = 1'b1;
      wpa_pkg::ST_RD_RESP:    ctrl.respond    = 1'b1;
      default:                ctrl            = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wpa_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/wpa_dp.sv */
// ----------------------------------------------------------------------------
// wpa_dp
// Item registers, weight multipliers, saturating update and sum stores.
// ----------------------------------------------------------------------------
module wpa_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wpa_pkg::ctrl_t                    ctrl,
  output wpa_pkg::stat_t                    stat,
  input  logic [wpa_pkg::CNT_W-1:0]         pixel_count,
  input  logic [1:0]                        in_cmd,
  input  logic [wpa_pkg::IDX_W-1:0]         in_pixel_index,
  input  logic [wpa_pkg::COLOR_W-1:0]       in_color_x,
  input  logic [wpa_pkg::COLOR_W-1:0]       in_color_y,
  input  logic [wpa_pkg::COLOR_W-1:0]       in_color_z,
  input  logic signed [wpa_pkg::WEIGHT_W-1:0] in_weight,
  output logic [wpa_pkg::OUT_W-1:0]         out_sum_x,
  output logic [wpa_pkg::OUT_W-1:0]         out_sum_y,
  output logic [wpa_pkg::OUT_W-1:0]         out_sum_z,
  output logic                              out_index_ok
);

  logic                              idx_ok;
  logic                              w_pos;
  logic [wpa_pkg::ADDR_W-1:0]        clr_ptr_r;
  logic [wpa_pkg::ADDR_W-1:0]        clr_ptr_nxt;
  logic [wpa_pkg::IDX_W-1:0]         idx_r;
  logic [wpa_pkg::COLOR_W-1:0]       cx_r;
  logic [wpa_pkg::COLOR_W-1:0]       cy_r;
  logic [wpa_pkg::COLOR_W-1:0]       cz_r;
  logic [wpa_pkg::WMAG_W-1:0]        w_r;
  logic                              ok_r;
  logic [wpa_pkg::MULT_W-1:0]        mx;
  logic [wpa_pkg::MULT_W-1:0]        my;
  logic [wpa_pkg::MULT_W-1:0]        mz;
  logic [wpa_pkg::PROD_W-1:0]        prod_x_r;
  logic [wpa_pkg::PROD_W-1:0]        prod_y_r;
  logic [wpa_pkg::PROD_W-1:0]        prod_z_r;
  logic [wpa_pkg::ADDR_W-1:0]        mem_addr;
  logic                              mem_we;
  logic [wpa_pkg::SUM_BITS-1:0]      rd_x;
  logic [wpa_pkg::SUM_BITS-1:0]      rd_y;
  logic [wpa_pkg::SUM_BITS-1:0]      rd_z;
  logic [wpa_pkg::SUM_BITS:0]        add_x;
  logic [wpa_pkg::SUM_BITS:0]        add_y;
  logic [wpa_pkg::SUM_BITS:0]        add_z;
  logic [wpa_pkg::SUM_BITS-1:0]      wr_x;
  logic [wpa_pkg::SUM_BITS-1:0]      wr_y;
  logic [wpa_pkg::SUM_BITS-1:0]      wr_z;

  assign idx_ok = (32'(in_pixel_index) < 32'(pixel_count)) &&
                  (32'(in_pixel_index) < 32'(wpa_pkg::MAX_PIXELS));
  assign w_pos  = !in_weight[wpa_pkg::WEIGHT_W-1] && (in_weight != '0);

  always_comb begin
    stat.clr_last = (clr_ptr_r == wpa_pkg::ADDR_W'(wpa_pkg::MAX_PIXELS - 1));
    case (in_cmd)
      wpa_pkg::CMD_DEPOSIT: begin
        stat.kind = (idx_ok && w_pos) ? wpa_pkg::KIND_DEPOSIT : wpa_pkg::KIND_NONE;
      end
      wpa_pkg::CMD_READ:  stat.kind = wpa_pkg::KIND_READ;
      wpa_pkg::CMD_CLEAR: stat.kind = wpa_pkg::KIND_CLEAR;
      default:            stat.kind = wpa_pkg::KIND_NONE;
    endcase
  end

  always_comb begin
    clr_ptr_nxt = clr_ptr_r;
    if (ctrl.load) begin
      clr_ptr_nxt = '0;
    end else if (ctrl.clear_step) begin
      clr_ptr_nxt = clr_ptr_r + wpa_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
    end else begin
      clr_ptr_r <= clr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      idx_r <= in_pixel_index;
      cx_r  <= in_color_x;
      cy_r  <= in_color_y;
      cz_r  <= in_color_z;
      w_r   <= in_weight[wpa_pkg::WMAG_W-1:0];
      ok_r  <= idx_ok;
    end
  end

  assign mx = wpa_pkg::MULT_W'(cx_r) * wpa_pkg::MULT_W'(w_r);
  assign my = wpa_pkg::MULT_W'(cy_r) * wpa_pkg::MULT_W'(w_r);
  assign mz = wpa_pkg::MULT_W'(cz_r) * wpa_pkg::MULT_W'(w_r);

  always_ff @(posedge clk) begin
    prod_x_r <= mx[wpa_pkg::MULT_W-1:wpa_pkg::FRAC_SHIFT];
    prod_y_r <= my[wpa_pkg::MULT_W-1:wpa_pkg::FRAC_SHIFT];
    prod_z_r <= mz[wpa_pkg::MULT_W-1:wpa_pkg::FRAC_SHIFT];
  end

  assign add_x = {1'b0, rd_x} + (wpa_pkg::SUM_BITS + 1)'(prod_x_r);
  assign add_y = {1'b0, rd_y} + (wpa_pkg::SUM_BITS + 1)'(prod_y_r);
  assign add_z = {1'b0, rd_z} + (wpa_pkg::SUM_BITS + 1)'(prod_z_r);

  always_comb begin
    if (ctrl.clear_step) begin
      wr_x = '0;
      wr_y = '0;
      wr_z = '0;
    end else begin
      wr_x = add_x[wpa_pkg::SUM_BITS] ? '1 : add_x[wpa_pkg::SUM_BITS-1:0];
      wr_y = add_y[wpa_pkg::SUM_BITS] ? '1 : add_y[wpa_pkg::SUM_BITS-1:0];
      wr_z = add_z[wpa_pkg::SUM_BITS] ? '1 : add_z[wpa_pkg::SUM_BITS-1:0];
    end
  end

  assign mem_addr = ctrl.clear_step ? clr_ptr_r : wpa_pkg::ADDR_W'(idx_r);
  assign mem_we   = ctrl.clear_step || ctrl.update;

  wpa_ram #(.WIDTH(wpa_pkg::SUM_BITS), .DEPTH(wpa_pkg::MAX_PIXELS)) u_ram_x (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (wr_x),
    .rdata (rd_x)
  );

  wpa_ram #(.WIDTH(wpa_pkg::SUM_BITS), .DEPTH(wpa_pkg::MAX_PIXELS)) u_ram_y (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (wr_y),
    .rdata (rd_y)
  );

  wpa_ram #(.WIDTH(wpa_pkg::SUM_BITS), .DEPTH(wpa_pkg::MAX_PIXELS)) u_ram_z (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (wr_z),
    .rdata (rd_z)
  );

  assign out_sum_x    = ok_r ? wpa_pkg::OUT_W'(rd_x) : '0;
  assign out_sum_y    = ok_r ? wpa_pkg::OUT_W'(rd_y) : '0;
  assign out_sum_z    = ok_r ? wpa_pkg::OUT_W'(rd_z) : '0;
  assign out_index_ok = ok_r;

endmodule

/* src/weighted_pixel_accumulator_top.sv */
// ----------------------------------------------------------------------------
// weighted_pixel_accumulator_top
// Scatter-add store of three saturating sums per pixel.
//
//   channel   handshake                 word
//   input     start & !busy             in_cmd, in_pixel_index, in_color_*,
//                                       in_weight
//   result    out_valid (one cycle)     out_sum_x/y/z, out_index_ok
//   config    psel & penable & pwrite   paddr, pwdata (prdata on read)
//
// Deposit: accept, fetch with multiply, update write.
// Read: accept, fetch, then the result on out_valid; skipped items stay idle.
// Clear: accept, then zero every entry, one entry per cycle through the single RAM port.
// Reset runs the same clearing pass with busy high.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module weighted_pixel_accumulator_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_cmd,
  input  logic [wpa_pkg::IDX_W-1:0]            in_pixel_index,
  input  logic [wpa_pkg::COLOR_W-1:0]          in_color_x,
  input  logic [wpa_pkg::COLOR_W-1:0]          in_color_y,
  input  logic [wpa_pkg::COLOR_W-1:0]          in_color_z,
  input  logic signed [wpa_pkg::WEIGHT_W-1:0]  in_weight,
  output logic                                 out_valid,
  output logic [wpa_pkg::OUT_W-1:0]            out_sum_x,
  output logic [wpa_pkg::OUT_W-1:0]            out_sum_y,
  output logic [wpa_pkg::OUT_W-1:0]            out_sum_z,
  output logic                                 out_index_ok,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wpa_pkg::PADDR_W-1:0]          paddr,
  input  logic [wpa_pkg::PDATA_W-1:0]          pwdata,
  output logic [wpa_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  wpa_pkg::ctrl_t            ctrl;
  wpa_pkg::stat_t            stat;
  logic [wpa_pkg::CNT_W-1:0] pixel_count;

  wpa_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pixel_count (pixel_count)
  );

  wpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  wpa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .pixel_count    (pixel_count),
    .in_cmd         (in_cmd),
    .in_pixel_index (in_pixel_index),
    .in_color_x     (in_color_x),
    .in_color_y     (in_color_y),
    .in_color_z     (in_color_z),
    .in_weight      (in_weight),
    .out_sum_x      (out_sum_x),
    .out_sum_y      (out_sum_y),
    .out_sum_z      (out_sum_z),
    .out_index_ok   (out_index_ok)
  );

  assign out_valid = ctrl.respond;

endmodule

/* src/wpa_checker.sv */
// ----------------------------------------------------------------------------
// wpa_checker
// Port-level checks of the weighted pixel accumulator, bound to the top.
// ----------------------------------------------------------------------------
`include "weighted_pixel_accumulator_top_assert.svh"

module wpa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   in_cmd,
  input logic                         out_valid,
  input logic [wpa_pkg::OUT_W-1:0]    out_sum_x,
  input logic [wpa_pkg::OUT_W-1:0]    out_sum_y,
  input logic [wpa_pkg::OUT_W-1:0]    out_sum_z,
  input logic                         out_index_ok
);

  logic rd_take;
  logic clr_take;
  logic sums_nz;

  assign rd_take  = start && !busy && (in_cmd == wpa_pkg::CMD_READ);
  assign clr_take = start && !busy && (in_cmd == wpa_pkg::CMD_CLEAR);
  assign sums_nz  = (out_sum_x != '0) || (out_sum_y != '0) || (out_sum_z != '0);

  `WPA_CHECK(a_read_result, rd_take |-> ##2 out_valid, "read word missing")
  `WPA_CHECK(a_single_strobe, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `WPA_CHECK(a_result_busy, out_valid |-> busy, "result outside a busy read")
  `WPA_CHECK(a_clear_busy, clr_take |=> busy, "clear not taken")
  `WPA_NEVER(a_bad_index_zero, out_valid && !out_index_ok && sums_nz, "bad index gave sums")

endmodule

bind weighted_pixel_accumulator_top wpa_checker u_wpa_checker (.*);
